// ----- rtl/rcpwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM capture package
// Shared widths, register reset values, register indices and the per-channel
// status record passed from each capture lane to the top level.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

  // Pin sample width and the widest channel space a query can address
  localparam int PIN_BITS         = 6;
  localparam int MAX_CHANNELS     = 8;
  localparam int NUM_CHANNELS_DEF = 6;

  localparam int QUERY_W = 3;
  localparam int WIDTH_W = 16;
  localparam int TIME_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [WIDTH_W-1:0] PULSE_MIN_RST     = 16'd900;
  localparam logic [WIDTH_W-1:0] PULSE_MAX_RST     = 16'd2100;
  localparam logic [TIME_W-1:0]  ALIVE_TIMEOUT_RST = 32'd100000;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_MIN     = 2'd0,
    CFG_PULSE_MAX     = 2'd1,
    CFG_ALIVE_TIMEOUT = 2'd2
  } cfg_reg_t;

  // Per-channel status, as seen after the current sample's update
  typedef struct packed {
    logic [WIDTH_W-1:0] width;      // stored width including this sample
    logic [TIME_W-1:0]  upd_time;   // timestamp of the previous store
    logic               updated;    // a width was stored before this sample
    logic               stored_now; // this sample stores a new width
  } chan_status_t;

endpackage

// ----- rtl/rc_pwm_multi_channel_capture_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM multi-channel capture, top level
// Measures servo pulse widths on up to six pins and reports the last accepted
// width and freshness of one queried channel per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample request: pin_levels,
//   time_us and query_channel. Each accepted request yields exactly one
//   result on the output channel (out_valid/out_ready): pulse_width_us and
//   channel_alive for the queried channel, after this sample's update.
//   The result is registered at the accepting edge and shows on the next cycle.
//   Throughput is one request per cycle while the receiver takes each result;
//   the lanes update and the result register loads in the same edge.
//   in_ready stays high while the result register is empty or being drained,
//   so a stalled receiver holds the result and stops intake only while the
//   single result register is full.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
//   outside reset; indices beyond the register list are ignored.
//   Reset clears pin history, rise and store flags, stored widths and the
//   result valid flag, and restores the register defaults. No request or write
//   is taken while rst is high.
// ----------------------------------------------------------------------------
module rc_pwm_multi_channel_capture_top
  import rcpwm_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Sample requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIN_BITS-1:0]   pin_levels,
  input  logic [TIME_W-1:0]     time_us,
  input  logic [QUERY_W-1:0]    query_channel,
  // Results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WIDTH_W-1:0]    pulse_width_us,
  output logic                  channel_alive,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WIDTH_W-1:0]  pulse_min;
  logic [WIDTH_W-1:0]  pulse_max;
  logic [TIME_W-1:0]   alive_timeout;
  logic [PIN_BITS-1:0] previous_levels;

  logic                accept;
  chan_status_t        status_all [MAX_CHANNELS];
  chan_status_t        sel;
  logic [TIME_W-1:0]   age;
  logic                alive_next;

  assign in_ready  = ~rst & (~out_valid | out_ready);
  assign cfg_ready = ~rst;
  assign accept    = in_valid & in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min     <= PULSE_MIN_RST;
      pulse_max     <= PULSE_MAX_RST;
      alive_timeout <= ALIVE_TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PULSE_MIN:     pulse_min     <= cfg_data[WIDTH_W-1:0];
        CFG_PULSE_MAX:     pulse_max     <= cfg_data[WIDTH_W-1:0];
        CFG_ALIVE_TIMEOUT: alive_timeout <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the previous pin sample for edge detection
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels <= '0;
    end else if (accept) begin
      previous_levels <= pin_levels;
    end
  end

  // One lane per channel that has a pin; other channels report nothing
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_chan
    if (i < NUM_CHANNELS && i < PIN_BITS) begin : g_lane
      rcpwm_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .en         (accept),
        .level      (pin_levels[i]),
        .prev_level (previous_levels[i]),
        .now        (time_us),
        .pulse_min  (pulse_min),
        .pulse_max  (pulse_max),
        .status     (status_all[i])
      );
    end else begin : g_none
      assign status_all[i] = '0;
    end
  end

  // Select the queried channel and work out freshness
  assign sel = status_all[query_channel];
  assign age = time_us - sel.upd_time;

  always_comb begin
    if (sel.stored_now) begin
      alive_next = (alive_timeout != '0);
    end else begin
      alive_next = sel.updated && (age < alive_timeout);
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pulse_width_us <= sel.width;
      channel_alive  <= alive_next;
    end
  end

endmodule

// ----- rtl/rcpwm_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM capture lane
// Edge detection, pulse timing and window check for a single channel. Holds
// the rise timestamp, the last accepted width and its update timestamp.
// ----------------------------------------------------------------------------
module rcpwm_lane
  import rcpwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               level,
  input  logic               prev_level,
  input  logic [TIME_W-1:0]  now,
  input  logic [WIDTH_W-1:0] pulse_min,
  input  logic [WIDTH_W-1:0] pulse_max,
  output chan_status_t       status
);

  logic [TIME_W-1:0]  rise_time;
  logic               rise_seen;
  logic [WIDTH_W-1:0] stored_width;
  logic [TIME_W-1:0]  update_time;
  logic               updated_flag;

  logic               rise;
  logic               fall;
  logic [TIME_W-1:0]  elapsed;
  logic [WIDTH_W-1:0] width_cand;
  logic               in_window;
  logic               store;

  // Detect edges and measure the pulse against the window
  assign rise       = en & level & ~prev_level;
  assign fall       = en & ~level & prev_level & rise_seen;
  assign elapsed    = now - rise_time;
  assign width_cand = elapsed[WIDTH_W-1:0];
  assign in_window  = (width_cand >= pulse_min) && (width_cand <= pulse_max);
  assign store      = fall & in_window;

  // Record rises and accepted widths
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_seen    <= 1'b0;
      updated_flag <= 1'b0;
      stored_width <= '0;
    end else begin
      if (rise) begin
        rise_seen <= 1'b1;
      end
      if (store) begin
        updated_flag <= 1'b1;
        stored_width <= width_cand;
      end
    end
  end

  // Timestamps are only read behind their flags
  always_ff @(posedge clk) begin
    if (rise) begin
      rise_time <= now;
    end
    if (store) begin
      update_time <= now;
    end
  end

  // Report status including this sample
  always_comb begin
    status.width      = store ? width_cand : stored_width;
    status.upd_time   = update_time;
    status.updated    = updated_flag;
    status.stored_now = store;
  end

endmodule

// ----- rtl/rcpwm_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM capture port checker
// Watches the top level's ports for result timing, stall behaviour and the
// report for channels outside the configured range.
// ----------------------------------------------------------------------------
module rcpwm_check
  import rcpwm_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [QUERY_W-1:0] query_channel,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WIDTH_W-1:0] pulse_width_us,
  input logic               channel_alive
);

  // A held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_width_us)
                                && $stable(channel_alive))
    else $error("result changed while stalled");

  // Every accepted request shows its result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("result missing one cycle after request");

  // Intake stops only while a result waits for a stalled receiver
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // Channels outside the range report nothing
  a_bad_channel: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (32'(query_channel) >= NUM_CHANNELS)
    |=> pulse_width_us == '0 && !channel_alive)
    else $error("out-of-range channel reported data");

endmodule

bind rc_pwm_multi_channel_capture_top rcpwm_check #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_rcpwm_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .query_channel  (query_channel),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .pulse_width_us (pulse_width_us),
  .channel_alive  (channel_alive)
);
